/* design/fnvmix_pkg.sv */
package fnvmix_pkg;

  localparam int unsigned HASH_W = 64;
  localparam int unsigned HALF_W = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 32;
  localparam int unsigned OP_W   = 2;

  localparam logic [HASH_W-1:0] FNV_OFFSET = 64'hcbf29ce484222325;
  localparam logic [HASH_W-1:0] FNV_PRIME  = 64'h00000100000001b3;
  localparam logic [HASH_W-1:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
  localparam logic [HASH_W-1:0] MIX_MUL_B  = 64'h94d049bb133111eb;

  localparam logic [OP_W-1:0] OP_DATA   = 2'd0;
  localparam logic [OP_W-1:0] OP_HEADER = 2'd1;
  localparam logic [OP_W-1:0] OP_END    = 2'd2;

  // index of the last length byte of a header
  localparam logic [2:0] LEN_LAST_IDX = 3'd7;

  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] b;
  } mul_req_t;

endpackage

/* design/fnvmix_if.sv */
interface fnvmix_in_if;
  logic                             valid;
  logic                             ready;
  logic [fnvmix_pkg::OP_W-1:0]      operation;
  logic [fnvmix_pkg::BYTE_W-1:0]    data_byte;
  logic [fnvmix_pkg::LEN_W-1:0]     field_length;

  modport source (output valid, operation, data_byte, field_length, input ready);
  modport sink   (input valid, operation, data_byte, field_length, output ready);
endinterface

interface fnvmix_out_if;
  logic                             valid;
  logic                             ready;
  logic [fnvmix_pkg::HASH_W-1:0]    hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

/* design/fnv1a64_field_hash_with_mix_core.sv */
// Data byte: one multiply per transaction.
// Field header: eight chained multiplies per transaction.
// End of message: two multiplies plus xorshifts; the result goes through res_r into the output
// register, later while the output register is still held.
// Every multiply runs on the shared 32x32 multiplier.
// Synchronous active-low reset clears control and loads the FNV offset basis.
module fnv1a64_field_hash_with_mix_core (
  input logic          clk,
  input logic          rst_n,
  fnvmix_in_if.sink    in_if,
  fnvmix_out_if.source out_if
);
  import fnvmix_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_EMIT} state_t;

  state_t             state_r, state_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic               fin_r, fin_nxt;
  logic [2:0]         idx_r, idx_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [HASH_W-1:0]  hash_r, hash_nxt;
  logic [HASH_W-1:0]  res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [HASH_W-1:0]  out_hash_r, out_hash_nxt;

  mul_req_t           mreq;
  logic               mdone;
  logic [HASH_W-1:0]  mprod;

  logic [2:0]         idx_inc;
  logic [HASH_W-1:0]  len64;
  logic [BYTE_W-1:0]  len_byte_nxt;

  fnvmix_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mreq),
    .done (mdone),
    .prod (mprod)
  );

  assign idx_inc      = idx_r + 3'd1;
  assign len64        = {{(HASH_W-LEN_W){1'b0}}, len_r};
  assign len_byte_nxt = len64[{idx_inc, 3'b000} +: BYTE_W];

  assign in_if.ready       = (state_r == S_IDLE);
  assign out_if.valid      = out_valid_r;
  assign out_if.hash_value = out_hash_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    fin_nxt       = fin_r;
    idx_nxt       = idx_r;
    len_nxt       = len_r;
    hash_nxt      = hash_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r & ~out_if.ready;
    out_hash_nxt  = out_hash_r;
    mreq.start    = 1'b0;
    mreq.a        = hash_r;
    mreq.b        = FNV_PRIME;

    case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          op_nxt = in_if.operation;
          case (in_if.operation)
            OP_DATA: begin
              mreq.start = 1'b1;
              mreq.a     = hash_r ^ {{(HASH_W-BYTE_W){1'b0}}, in_if.data_byte};
              state_nxt  = S_MUL;
            end
            OP_HEADER: begin
              len_nxt    = in_if.field_length;
              idx_nxt    = 3'd0;
              mreq.start = 1'b1;
              mreq.a     = hash_r ^ {{(HASH_W-BYTE_W){1'b0}},
                                     in_if.field_length[BYTE_W-1:0]};
              state_nxt  = S_MUL;
            end
            OP_END: begin
              fin_nxt    = 1'b0;
              mreq.start = 1'b1;
              mreq.a     = hash_r ^ (hash_r >> 30);
              mreq.b     = MIX_MUL_A;
              state_nxt  = S_MUL;
            end
            default: ; // unused code: transaction taken, no effect
          endcase
        end
      end
      S_MUL: begin
        if (mdone) begin
          case (op_r)
            OP_DATA: begin
              hash_nxt  = mprod;
              state_nxt = S_IDLE;
            end
            OP_HEADER: begin
              hash_nxt = mprod;
              if (idx_r == LEN_LAST_IDX) begin
                idx_nxt   = 3'd0;
                state_nxt = S_IDLE;
              end else begin
                idx_nxt    = idx_inc;
                mreq.start = 1'b1;
                mreq.a     = mprod ^ {{(HASH_W-BYTE_W){1'b0}}, len_byte_nxt};
              end
            end
            OP_END: begin
              if (!fin_r) begin
                fin_nxt    = 1'b1;
                mreq.start = 1'b1;
                mreq.a     = mprod ^ (mprod >> 27);
                mreq.b     = MIX_MUL_B;
              end else begin
                res_nxt   = mprod ^ (mprod >> 31);
                hash_nxt  = FNV_OFFSET;
                state_nxt = S_EMIT;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_DATA;
      fin_r       <= 1'b0;
      idx_r       <= 3'd0;
      hash_r      <= FNV_OFFSET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      fin_r       <= fin_nxt;
      idx_r       <= idx_nxt;
      hash_r      <= hash_nxt;
      out_valid_r <= out_valid_nxt;
    end
    len_r      <= len_nxt;
    res_r      <= res_nxt;
    out_hash_r <= out_hash_nxt;
  end

endmodule

/* design/fnvmix_mul.sv */
// 64x64 -> low 64 bits, built from three 32x32 partial products on one multiplier.
module fnvmix_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fnvmix_pkg::mul_req_t          req,
  output logic                          done,
  output logic [fnvmix_pkg::HASH_W-1:0] prod
);
  import fnvmix_pkg::*;

  typedef enum logic [2:0] {M_IDLE, M_P0, M_P1, M_P2, M_ACC} mstate_t;

  mstate_t               mst_r, mst_nxt;
  logic [HASH_W-1:0]     a_r, a_nxt;
  logic [HASH_W-1:0]     b_r, b_nxt;
  logic [HASH_W-1:0]     p_r, p_nxt;
  logic [HASH_W-1:0]     acc_r, acc_nxt;
  logic                  done_r, done_nxt;
  logic [HALF_W-1:0]     op_a;
  logic [HALF_W-1:0]     op_b;

  // operand select for the shared multiplier
  always_comb begin
    op_a = a_r[HALF_W-1:0];
    op_b = b_r[HALF_W-1:0];
    case (mst_r)
      M_P1:    op_a = a_r[HASH_W-1:HALF_W];
      M_P2:    op_b = b_r[HASH_W-1:HALF_W];
      default: ;
    endcase
  end

  always_comb begin
    mst_nxt  = mst_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    p_nxt    = p_r;
    acc_nxt  = acc_r;
    done_nxt = 1'b0;
    case (mst_r)
      M_IDLE: begin
        if (req.start) begin
          a_nxt   = req.a;
          b_nxt   = req.b;
          mst_nxt = M_P0;
        end
      end
      M_P0: begin
        p_nxt   = HASH_W'(op_a) * HASH_W'(op_b);
        mst_nxt = M_P1;
      end
      M_P1: begin
        p_nxt   = HASH_W'(op_a) * HASH_W'(op_b);
        acc_nxt = p_r;
        mst_nxt = M_P2;
      end
      M_P2: begin
        p_nxt   = HASH_W'(op_a) * HASH_W'(op_b);
        // cross terms only reach the upper half
        acc_nxt = {acc_r[HASH_W-1:HALF_W] + p_r[HALF_W-1:0], acc_r[HALF_W-1:0]};
        mst_nxt = M_ACC;
      end
      M_ACC: begin
        acc_nxt  = {acc_r[HASH_W-1:HALF_W] + p_r[HALF_W-1:0], acc_r[HALF_W-1:0]};
        done_nxt = 1'b1;
        mst_nxt  = M_IDLE;
      end
      default: mst_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mst_r  <= M_IDLE;
      done_r <= 1'b0;
    end else begin
      mst_r  <= mst_nxt;
      done_r <= done_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    p_r   <= p_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule
